@@ rtl/afs_pkg.sv @@
// Package with shared constants for the animation frame sequencer.
`timescale 1ns / 1ps

package afs_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int MAX_FRAMES_DEFAULT = 256;
   localparam int TIME_BITS_DEFAULT  = 32;

   // Field widths of the ports.
   localparam int FUNC_W   = 3;
   localparam int NOW_W    = 32;
   localparam int MODE_W   = 3;
   localparam int FRAME_W  = 8;
   localparam int FCOUNT_W = 9;
   localparam int PERIOD_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Largest frame count that the count register can hold.
   localparam int FCOUNT_MAX = 511;

   // Register reset values.
   localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 9'd1;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MS   = 1'b1;

   // Command codes.
   localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PLAY      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PLAY_BACK = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LOOP      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PINGPONG  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_STOP      = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_REFRESH   = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SET_NEXT  = 3'd7;

   // Play mode codes, shared by mode, queued mode and order.
   localparam logic [MODE_W-1:0] MODE_STOP = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PLAY = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BACK = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOOP = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PING = 3'd4;

endpackage

@@ rtl/animation_frame_sequencer.sv @@
// Top level of the animation frame sequencer: request register, frame logic, result register.
`timescale 1ns / 1ps

// The sequencer takes one request per clock cycle, unless a full result register stalls
// it, and returns one result per request: the request is captured in an input register,
// and when the result register is free the frame, mode and step-time state is updated and
// the result register loaded. Back-to-back requests see the state left by the one before,
// so the sustained rate is one request per cycle whenever the result side keeps taking
// results. A tick steps the frame when the wrap-safe time since the last step reaches
// period_ms; when a one-shot play ends, the queued mode starts at once and the queue
// clears. Configuration writes take effect on the next cycle and are meant to be done
// while no request is in flight.
module animation_frame_sequencer
   import afs_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [NOW_W-1:0]      req_now_ms,
   input  logic [MODE_W-1:0]     req_order,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FRAME_W-1:0]    rsp_frame,
   output logic [MODE_W-1:0]     rsp_mode,
   output logic [MODE_W-1:0]     rsp_queued_mode,
   output logic                  rsp_advanced,
   output logic                  rsp_finished,
   // Configuration write port.
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Frame indexes never exceed what the count register and the size limit allow.
   localparam int MAX_EFF   = (MAX_FRAMES < FCOUNT_MAX) ? MAX_FRAMES : FCOUNT_MAX;
   localparam int FIDX_BITS = $clog2(MAX_EFF);

   // Configuration registers.
   logic [FCOUNT_W-1:0]  fcount_ff;
   logic [PERIOD_W-1:0]  period_ff;

   // Input register.
   logic                 in_valid_ff;
   logic [FUNC_W-1:0]    in_func_ff;
   logic [NOW_W-1:0]     in_now_ff;
   logic [MODE_W-1:0]    in_order_ff;

   // Sequencer state.
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [MODE_W-1:0]    next_ff, next_in;
   logic [FIDX_BITS-1:0] frame_ff, frame_in;
   logic                 rev_ff, rev_in;
   logic [TIME_BITS-1:0] step_time_ff, step_time_in;

   // Result register.
   logic                 out_valid_ff;
   logic [FRAME_W-1:0]   out_frame_ff;
   logic [MODE_W-1:0]    out_mode_ff;
   logic [MODE_W-1:0]    out_queued_ff;
   logic                 out_adv_ff, adv_in;
   logic                 out_fin_ff, fin_in;

   // Working signals.
   logic                 out_load;
   logic [FCOUNT_W-1:0]  fcount_m1;
   logic [FIDX_BITS-1:0] last_frame;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic                 step_due;
   logic [MODE_W-1:0]    start_mode;
   logic [FIDX_BITS-1:0] ping_frame;

   // Handshake: the result register loads when it is empty or being drained.
   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;

   // Last valid frame index, with a zero count taken as one and large counts clamped.
   assign fcount_m1 = fcount_ff - FCOUNT_W'(1);
   always_comb begin
      if (fcount_ff == '0) begin
         last_frame = '0;
      end else if (fcount_ff > FCOUNT_W'(MAX_EFF)) begin
         last_frame = FIDX_BITS'(MAX_EFF - 1);
      end else begin
         last_frame = FIDX_BITS'(fcount_m1);
      end
   end

   // Wrap-safe elapsed time since the last step.
   assign now_t    = TIME_BITS'(in_now_ff);
   assign elapsed  = now_t - step_time_ff;
   assign step_due = (mode_ff != MODE_STOP) && (elapsed >= TIME_BITS'(period_ff));

   // Ping-pong step before the direction update.
   always_comb begin
      if (rev_ff) begin
         ping_frame = (frame_ff > '0) ? frame_ff - FIDX_BITS'(1) : '0;
      end else begin
         ping_frame = (frame_ff < last_frame) ? frame_ff + FIDX_BITS'(1) : last_frame;
      end
   end

   // Next state for the request in the input register.
   always_comb begin
      mode_in      = mode_ff;
      next_in      = next_ff;
      frame_in     = frame_ff;
      rev_in       = rev_ff;
      step_time_in = step_time_ff;
      adv_in       = 1'b0;
      fin_in       = 1'b0;
      start_mode   = MODE_STOP;

      case (in_func_ff)
         FUNC_TICK: begin
            if (step_due) begin
               step_time_in = now_t;
               case (mode_ff)
                  MODE_PLAY: begin
                     if (frame_ff < last_frame) begin
                        frame_in = frame_ff + FIDX_BITS'(1);
                        adv_in   = 1'b1;
                     end else begin
                        fin_in     = 1'b1;
                        mode_in    = MODE_STOP;
                        next_in    = MODE_STOP;
                        start_mode = next_ff;
                     end
                  end
                  MODE_BACK: begin
                     if (frame_ff > '0) begin
                        frame_in = frame_ff - FIDX_BITS'(1);
                        adv_in   = 1'b1;
                     end else begin
                        fin_in     = 1'b1;
                        mode_in    = MODE_STOP;
                        next_in    = MODE_STOP;
                        start_mode = next_ff;
                     end
                  end
                  MODE_LOOP: begin
                     frame_in = (frame_ff < last_frame) ? frame_ff + FIDX_BITS'(1) : '0;
                     adv_in   = 1'b1;
                  end
                  MODE_PING: begin
                     adv_in = 1'b1;
                     if (last_frame == '0) begin
                        // A single frame holds at zero facing forward.
                        frame_in = '0;
                        rev_in   = 1'b0;
                     end else begin
                        frame_in = ping_frame;
                        if (ping_frame == '0) begin
                           rev_in = 1'b0;
                        end else if (ping_frame >= last_frame) begin
                           rev_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     mode_in = MODE_STOP;
                  end
               endcase
            end
         end
         FUNC_PLAY: begin
            start_mode = MODE_PLAY;
         end
         FUNC_PLAY_BACK: begin
            start_mode = MODE_BACK;
         end
         FUNC_LOOP: begin
            start_mode = MODE_LOOP;
         end
         FUNC_PINGPONG: begin
            start_mode = MODE_PING;
         end
         FUNC_STOP: begin
            step_time_in = now_t;
            mode_in      = MODE_STOP;
         end
         FUNC_REFRESH: begin
            mode_in  = MODE_STOP;
            next_in  = MODE_STOP;
            frame_in = '0;
         end
         default: begin
            // Queue the next order; an unknown order queues stop.
            next_in = (in_order_ff <= MODE_PING) ? in_order_ff : MODE_STOP;
         end
      endcase

      // Start a play mode, either by command or from the queue at the end of a one-shot.
      case (start_mode)
         MODE_PLAY: begin
            step_time_in = now_t;
            mode_in      = MODE_PLAY;
            frame_in     = '0;
         end
         MODE_BACK: begin
            step_time_in = now_t;
            mode_in      = MODE_BACK;
            frame_in     = last_frame;
         end
         MODE_LOOP: begin
            step_time_in = now_t;
            mode_in      = MODE_LOOP;
            frame_in     = '0;
         end
         MODE_PING: begin
            step_time_in = now_t;
            mode_in      = MODE_PING;
            frame_in     = '0;
            rev_in       = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fcount_ff <= FCOUNT_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_COUNT: fcount_ff <= csr_data[FCOUNT_W-1:0];
            CSR_PERIOD_MS:   period_ff <= csr_data[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff  <= req_func;
         in_now_ff   <= req_now_ms;
         in_order_ff <= req_order;
      end
   end

   // Sequencer state, updated as each request moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOP;
         next_ff      <= MODE_STOP;
         frame_ff     <= '0;
         rev_ff       <= 1'b0;
         step_time_ff <= '0;
      end else if (out_load) begin
         mode_ff      <= mode_in;
         next_ff      <= next_in;
         frame_ff     <= frame_in;
         rev_ff       <= rev_in;
         step_time_ff <= step_time_in;
      end
   end

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_frame_ff  <= FRAME_W'(frame_in);
         out_mode_ff   <= mode_in;
         out_queued_ff <= next_in;
         out_adv_ff    <= adv_in;
         out_fin_ff    <= fin_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_frame       = out_frame_ff;
   assign rsp_mode        = out_mode_ff;
   assign rsp_queued_mode = out_queued_ff;
   assign rsp_advanced    = out_adv_ff;
   assign rsp_finished    = out_fin_ff;

endmodule

@@ sim/tb_animation_frame_sequencer.sv @@
// Testbench for the animation frame sequencer: random stimulus checked against a frame predictor.
`timescale 1ns / 1ps

import afs_pkg::*;

// One result of the sequencer, as it should appear on the result channel.
typedef struct packed {
   logic [FRAME_W-1:0] frame;
   logic [MODE_W-1:0]  mode;
   logic [MODE_W-1:0]  queued_mode;
   logic               advanced;
   logic               finished;
} frame_result_type;

// Tracks the sequencer state and checks every result in order.
class frame_scoreboard;
   logic [FCOUNT_W-1:0] frame_count;
   logic [PERIOD_W-1:0] period_ms;
   logic [MODE_W-1:0]   play_mode;
   logic [MODE_W-1:0]   next_mode;
   logic [FRAME_W-1:0]  frame_idx;
   logic                reverse_dir;
   logic [NOW_W-1:0]    last_step_ms;
   frame_result_type    expected_frames[$];
   int                  errors;

   function new();
      frame_count  = FCOUNT_RESET;
      period_ms    = PERIOD_RESET;
      play_mode    = MODE_STOP;
      next_mode    = MODE_STOP;
      frame_idx    = '0;
      reverse_dir  = 1'b0;
      last_step_ms = '0;
      errors       = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      if (index == CSR_FRAME_COUNT) begin
         frame_count = data[FCOUNT_W-1:0];
      end else begin
         period_ms = data[PERIOD_W-1:0];
      end
   endfunction

   // A count of zero means one frame; counts past the frame store saturate.
   function logic [FCOUNT_W-1:0] frames_in_use();
      if (frame_count == 0) return FCOUNT_W'(1);
      if (frame_count > MAX_FRAMES_DEFAULT) return FCOUNT_W'(MAX_FRAMES_DEFAULT);
      return frame_count;
   endfunction

   function void start_playback(logic [MODE_W-1:0] m, logic [NOW_W-1:0] now);
      case (m)
         MODE_PLAY, MODE_LOOP: begin
            last_step_ms = now;
            play_mode    = m;
            frame_idx    = '0;
         end
         MODE_BACK: begin
            last_step_ms = now;
            play_mode    = m;
            frame_idx    = FRAME_W'(frames_in_use() - 1'b1);
         end
         MODE_PING: begin
            last_step_ms = now;
            play_mode    = m;
            frame_idx    = '0;
            reverse_dir  = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // A one-shot play has run out: stop, then launch whatever was queued.
   function void end_one_shot(logic [NOW_W-1:0] now);
      play_mode = MODE_STOP;
      start_playback(next_mode, now);
      next_mode = MODE_STOP;
   endfunction

   function int pending();
      return expected_frames.size();
   endfunction

   // Applies one accepted request to the tracked state and queues its result.
   function void note_request(logic [FUNC_W-1:0] func, logic [NOW_W-1:0] now,
                              logic [MODE_W-1:0] order);
      logic [NOW_W-1:0]    elapsed;
      logic [FCOUNT_W-1:0] cnt;
      logic [FRAME_W-1:0]  last_frame;
      frame_result_type    res;
      res = '0;
      case (func)
         FUNC_TICK: begin
            elapsed    = now - last_step_ms;
            cnt        = frames_in_use();
            last_frame = FRAME_W'(cnt - 1'b1);
            if (play_mode != MODE_STOP && elapsed >= NOW_W'(period_ms)) begin
               last_step_ms = now;
               case (play_mode)
                  MODE_PLAY: begin
                     if (frame_idx < last_frame) begin
                        frame_idx    = frame_idx + 1'b1;
                        res.advanced = 1'b1;
                     end else begin
                        res.finished = 1'b1;
                        end_one_shot(now);
                     end
                  end
                  MODE_BACK: begin
                     if (frame_idx > 0) begin
                        frame_idx    = frame_idx - 1'b1;
                        res.advanced = 1'b1;
                     end else begin
                        res.finished = 1'b1;
                        end_one_shot(now);
                     end
                  end
                  MODE_LOOP: begin
                     frame_idx    = (frame_idx < last_frame) ? frame_idx + 1'b1 : '0;
                     res.advanced = 1'b1;
                  end
                  MODE_PING: begin
                     res.advanced = 1'b1;
                     // With a single frame the bounce holds frame 0 going forward.
                     if (cnt == 1) begin
                        frame_idx   = '0;
                        reverse_dir = 1'b0;
                     end else begin
                        if (reverse_dir) begin
                           frame_idx = (frame_idx > 0) ? frame_idx - 1'b1 : '0;
                        end else begin
                           frame_idx = (frame_idx < last_frame) ? frame_idx + 1'b1 : last_frame;
                        end
                        if (frame_idx == 0) begin
                           reverse_dir = 1'b0;
                        end else if (frame_idx >= last_frame) begin
                           reverse_dir = 1'b1;
                        end
                     end
                  end
                  default: begin
                     play_mode = MODE_STOP;
                  end
               endcase
            end
         end
         FUNC_PLAY:      start_playback(MODE_PLAY, now);
         FUNC_PLAY_BACK: start_playback(MODE_BACK, now);
         FUNC_LOOP:      start_playback(MODE_LOOP, now);
         FUNC_PINGPONG:  start_playback(MODE_PING, now);
         FUNC_STOP: begin
            last_step_ms = now;
            play_mode    = MODE_STOP;
         end
         FUNC_REFRESH: begin
            play_mode = MODE_STOP;
            next_mode = MODE_STOP;
            frame_idx = '0;
         end
         default: begin
            next_mode = (order <= MODE_PING) ? order : MODE_STOP;
         end
      endcase
      res.frame       = frame_idx;
      res.mode        = play_mode;
      res.queued_mode = next_mode;
      expected_frames.push_back(res);
   endfunction

   // Compares one accepted result with the oldest expected one.
   function void check_result(logic [FRAME_W-1:0] frame, logic [MODE_W-1:0] mode,
                              logic [MODE_W-1:0] queued_mode, logic advanced,
                              logic finished);
      frame_result_type exp_res;
      if (expected_frames.size() == 0) begin
         $error("unexpected result: frame %0d mode %0d", frame, mode);
         errors++;
         return;
      end
      exp_res = expected_frames.pop_front();
      if (frame !== exp_res.frame) begin
         $error("frame: expected %0d, actual %0d", exp_res.frame, frame);
         errors++;
      end
      if (mode !== exp_res.mode) begin
         $error("mode: expected %0d, actual %0d", exp_res.mode, mode);
         errors++;
      end
      if (queued_mode !== exp_res.queued_mode) begin
         $error("queued_mode: expected %0d, actual %0d", exp_res.queued_mode, queued_mode);
         errors++;
      end
      if (advanced !== exp_res.advanced) begin
         $error("advanced: expected %0d, actual %0d", exp_res.advanced, advanced);
         errors++;
      end
      if (finished !== exp_res.finished) begin
         $error("finished: expected %0d, actual %0d", exp_res.finished, finished);
         errors++;
      end
   endfunction
endclass

module tb_animation_frame_sequencer;

   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASE_ITEMS  = 130;
   localparam int TAIL_CYCLES  = 10;
   localparam int DRAIN_CYCLES = 4;
   localparam logic [MODE_W-1:0] BAD_ORDER = 3'd7;
   localparam logic [MODE_W-1:0] ODD_ORDER = 3'd5;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [NOW_W-1:0]      req_now_ms = '0;
   logic [MODE_W-1:0]     req_order = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [FRAME_W-1:0]    rsp_frame;
   logic [MODE_W-1:0]     rsp_mode;
   logic [MODE_W-1:0]     rsp_queued_mode;
   logic                  rsp_advanced;
   logic                  rsp_finished;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   frame_scoreboard sb;
   int              idle_cycles = 0;
   int              requests_sent = 0;
   int              req_calm = 0;
   int              rsp_calm = 0;

   always #10 clock = ~clock;

   animation_frame_sequencer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_now_ms      (req_now_ms),
      .req_order       (req_order),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame       (rsp_frame),
      .rsp_mode        (rsp_mode),
      .rsp_queued_mode (rsp_queued_mode),
      .rsp_advanced    (rsp_advanced),
      .rsp_finished    (rsp_finished),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Wait before the next handshake, with occasional stretches of no waiting at all.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // Offers one request and waits until it is taken.
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [NOW_W-1:0] now,
                               input logic [MODE_W-1:0] order);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_now_ms <= now;
      req_order  <= order;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, now, order);
      requests_sent++;
   endtask

   // Registers change only once every result is back and the pipe is empty.
   task automatic configure(input logic [FCOUNT_W-1:0] fc, input logic [PERIOD_W-1:0] per);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FRAME_COUNT;
      csr_data     <= CSR_DATA_W'(fc);
      @(posedge clock);
      sb.write_reg(CSR_FRAME_COUNT, CSR_DATA_W'(fc));
      csr_index <= CSR_PERIOD_MS;
      csr_data  <= per;
      @(posedge clock);
      sb.write_reg(CSR_PERIOD_MS, per);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly start commands followed by runs of ticks spaced around the period, plus noise.
   task automatic run_phase(input int fc, input int per, input int items);
      int                 target;
      int                 run_len;
      int                 run_max;
      logic [NOW_W-1:0]   clock_ms;
      logic [NOW_W-1:0]   step_ms;
      logic [FUNC_W-1:0]  cmd;
      configure(FCOUNT_W'(fc), PERIOD_W'(per));
      target  = requests_sent + items;
      run_max = 2 * sb.frames_in_use() + 4;
      if (run_max > 40) run_max = 40;
      if ($urandom_range(0, 1) == 1) begin
         clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * per + 10);
      end else begin
         clock_ms = $urandom;
      end
      while (requests_sent < target) begin
         case ($urandom_range(0, 9))
            0: begin
               send_request(FUNC_W'($urandom_range(0, 7)), $urandom,
                            MODE_W'($urandom_range(0, 7)));
            end
            1: begin
               case ($urandom_range(0, 2))
                  0: cmd = FUNC_STOP;
                  1: cmd = FUNC_REFRESH;
                  default: cmd = FUNC_SET_NEXT;
               endcase
               clock_ms += $urandom_range(0, 3);
               send_request(cmd, clock_ms, MODE_W'($urandom_range(0, 7)));
            end
            default: begin
               if ($urandom_range(0, 1) == 1) begin
                  send_request(FUNC_SET_NEXT, clock_ms, MODE_W'($urandom_range(0, 7)));
               end
               case ($urandom_range(0, 3))
                  0: cmd = FUNC_PLAY;
                  1: cmd = FUNC_PLAY_BACK;
                  2: cmd = FUNC_LOOP;
                  default: cmd = FUNC_PINGPONG;
               endcase
               clock_ms += $urandom_range(0, 3);
               send_request(cmd, clock_ms, MODE_W'($urandom_range(0, 7)));
               run_len = $urandom_range(1, run_max);
               repeat (run_len) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3, 4, 5: step_ms = per + $urandom_range(0, 3);
                     6: step_ms = (per > 0) ? per - 1 : 0;
                     7, 8: step_ms = $urandom_range(0, per);
                     default: step_ms = $urandom_range(0, 3 * per + 5);
                  endcase
                  clock_ms += step_ms;
                  send_request(FUNC_TICK, clock_ms, MODE_W'($urandom_range(0, 7)));
               end
            end
         endcase
      end
   endtask

   // Result side: random stalls, then check each result taken.
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_wait(rsp_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_frame, rsp_mode, rsp_queued_mode, rsp_advanced, rsp_finished);
      end
   end

   // Request side: reset, directed sequence, then random phases over several settings.
   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Three frames, period of 10 ms, starting just below the time wrap.
      configure(3, 10);
      send_request(FUNC_TICK, 32'h0000_0000, MODE_STOP);
      send_request(FUNC_SET_NEXT, 32'h0000_0000, BAD_ORDER);
      send_request(FUNC_SET_NEXT, 32'h0000_0000, MODE_LOOP);
      send_request(FUNC_PLAY, 32'hFFFF_FFF8, MODE_STOP);
      send_request(FUNC_TICK, 32'hFFFF_FFFF, MODE_STOP);
      send_request(FUNC_TICK, 32'h0000_0002, MODE_STOP);
      send_request(FUNC_TICK, 32'd12, MODE_STOP);
      // The forward play ends here and the queued loop takes over.
      send_request(FUNC_TICK, 32'd22, MODE_STOP);
      send_request(FUNC_TICK, 32'd32, MODE_STOP);
      send_request(FUNC_TICK, 32'd42, MODE_STOP);
      send_request(FUNC_TICK, 32'd52, MODE_STOP);
      send_request(FUNC_PINGPONG, 32'd60, MODE_STOP);
      send_request(FUNC_TICK, 32'd70, MODE_STOP);
      send_request(FUNC_TICK, 32'd80, MODE_STOP);
      send_request(FUNC_TICK, 32'd90, MODE_STOP);
      send_request(FUNC_TICK, 32'd100, MODE_STOP);
      send_request(FUNC_PLAY_BACK, 32'd110, MODE_STOP);
      send_request(FUNC_TICK, 32'd120, MODE_STOP);
      send_request(FUNC_TICK, 32'd130, MODE_STOP);
      send_request(FUNC_TICK, 32'd140, MODE_STOP);
      send_request(FUNC_STOP, 32'hFFFF_FFFF, MODE_STOP);
      send_request(FUNC_REFRESH, 32'h0000_0000, MODE_STOP);
      send_request(FUNC_SET_NEXT, 32'h8000_0000, ODD_ORDER);
      send_request(FUNC_TICK, 32'hFFFF_FFFF, MODE_STOP);

      // Large counts first, then smaller ones so a running frame lands past the end.
      run_phase(256, 65535, PHASE_ITEMS);
      run_phase(2, 1, PHASE_ITEMS);
      run_phase(511, 20, PHASE_ITEMS);
      run_phase(5, 0, PHASE_ITEMS);
      run_phase(257, 3, PHASE_ITEMS);
      run_phase(1, 5, PHASE_ITEMS);
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(17, 50, PHASE_ITEMS);
      run_phase(3, 7, PHASE_ITEMS);
      run_phase($urandom_range(1, 300), $urandom_range(0, 200), PHASE_ITEMS);

      // Let every result come back, then watch a little longer for strays.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
